// ----- hdl/adic_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adic_pkg
// Shared constants, types and step functions for the register abstraction
// intersection check.
// ----------------------------------------------------------------------------
package adic_pkg;

    localparam int WORD_W          = 64;
    localparam int HALF_W          = 32;
    localparam int NUM_SPANS       = 2;
    localparam int PIECES_PER_SPAN = 3;
    localparam int NUM_PIECES      = NUM_SPANS * PIECES_PER_SPAN;
    localparam int IVALS_PER_PIECE = 4;
    localparam int NUM_IVALS       = NUM_PIECES * IVALS_PER_PIECE;
    localparam int SMEAR_STEPS     = 6;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WORD_W-1:0] LOW_HALF  = {{HALF_W{1'b0}}, {HALF_W{1'b1}}};
    localparam logic [HALF_W-1:0] HALF_ONES = {HALF_W{1'b1}};
    localparam logic [HALF_W-1:0] HALF_ZERO = {HALF_W{1'b0}};

    // Position of an interval within the group that belongs to one piece.
    localparam int IVAL_WIDE  = 0;
    localparam int IVAL_LOW   = 1;
    localparam int IVAL_LOW_A = 2;
    localparam int IVAL_LOW_B = 3;

    typedef struct packed {
        logic              en;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
    } t_range;

    typedef struct packed {
        logic                           viol;
        logic                           norm;
        t_range [NUM_SPANS-1:0]         span;
        logic [HALF_W-1:0]              wl;
        logic [HALF_W-1:0]              wh;
        logic [HALF_W-1:0]              wsl;
        logic [HALF_W-1:0]              wsh;
        logic [WORD_W-1:0]              v;
        logic [WORD_W-1:0]              m;
    } t_item;

    typedef struct packed {
        logic              en;
        logic              is_mem;
        logic              vhb;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] cand;
        logic [WORD_W-1:0] above;
    } t_stepa;

    typedef struct packed {
        logic              en;
        logic [WORD_W-1:0] nxt;
        logic [WORD_W-1:0] hi;
    } t_stepb;

    function automatic logic [WORD_W-1:0] fn_max(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [WORD_W-1:0] fn_min(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // First half of the next-member step: find the highest known bit where
    // the bound disagrees with the tristate value.
    function automatic t_stepa fn_step_a(input t_range r,
                                         input logic [WORD_W-1:0] v,
                                         input logic [WORD_W-1:0] m);
        t_stepa            res;
        logic [WORD_W-1:0] diff;
        logic [WORD_W-1:0] smear;
        logic [WORD_W-1:0] hb;
        diff  = (r.lo ^ v) & ~m;
        smear = diff;
        for (int i = 0; i < SMEAR_STEPS; i++) begin
            smear = smear | (smear >> (1 << i));
        end
        hb         = smear & ~(smear >> 1);
        res.en     = r.en;
        res.is_mem = ((r.lo & ~m) == v);
        res.vhb    = |(v & hb);
        res.lo     = r.lo;
        res.hi     = r.hi;
        res.above  = ~smear;
        res.cand   = ~r.lo & m & ~smear;
        return res;
    endfunction

    // Second half: build the smallest member at or above the bound.
    function automatic t_stepb fn_step_b(input t_stepa a,
                                         input logic [WORD_W-1:0] v,
                                         input logic [WORD_W-1:0] m);
        t_stepb            res;
        logic [WORD_W-1:0] low_incl;
        logic [WORD_W-1:0] j;
        low_incl = a.cand ^ (a.cand - {{(WORD_W-1){1'b0}}, 1'b1});
        j        = low_incl & a.cand;
        res.hi   = a.hi;
        if (a.is_mem) begin
            res.nxt = a.lo;
            res.en  = a.en;
        end else if (a.vhb) begin
            res.nxt = (a.lo & m & a.above) | v;
            res.en  = a.en;
        end else if (a.cand == '0) begin
            res.nxt = a.lo;
            res.en  = 1'b0;
        end else begin
            res.nxt = (a.lo & m & ~low_incl) | j | v;
            res.en  = a.en;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/adic_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adic_front
// Accepts items, flags inverted ranges and reduces the 64-bit ranges to at
// most two spans, registered for the queue.
// ----------------------------------------------------------------------------
module adic_front
    import adic_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [WORD_W-1:0]        i_u_low,
    input  wire logic [WORD_W-1:0]        i_u_high,
    input  wire logic signed [WORD_W-1:0] i_s_low,
    input  wire logic signed [WORD_W-1:0] i_s_high,
    input  wire logic [HALF_W-1:0]        i_w_low,
    input  wire logic [HALF_W-1:0]        i_w_high,
    input  wire logic signed [HALF_W-1:0] i_ws_low,
    input  wire logic signed [HALF_W-1:0] i_ws_high,
    input  wire logic [WORD_W-1:0]        i_known_bits,
    input  wire logic [WORD_W-1:0]        i_unknown_mask,
    output logic                          o_push,
    input  wire logic                     i_q_full,
    output t_item                         o_item
);

    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic [WORD_W-1:0] sl_u;
    logic [WORD_W-1:0] sh_u;
    logic [WORD_W-1:0] l_cut;
    logic [WORD_W-1:0] r_cut;
    logic              viol;

    assign o_in_ready = !r_valid || !i_q_full;
    assign o_push     = r_valid && !i_q_full;
    assign o_item     = r_item;

    always_comb begin
        sl_u  = i_s_low;
        sh_u  = i_s_high;
        viol  = (i_u_low > i_u_high) || (i_s_low > i_s_high) ||
                (i_w_low > i_w_high) || (i_ws_low > i_ws_high);
        l_cut = fn_max(i_u_low, sl_u);
        r_cut = fn_min(i_u_high, sh_u);

        n_item.viol = viol;
        // The low signed range is split at the sign wrap when its raw bits
        // are out of unsigned order.
        n_item.norm = ($unsigned(i_ws_low) <= $unsigned(i_ws_high));
        n_item.wl   = i_w_low;
        n_item.wh   = i_w_high;
        n_item.wsl  = i_ws_low;
        n_item.wsh  = i_ws_high;
        n_item.m    = i_unknown_mask;
        n_item.v    = i_known_bits & ~i_unknown_mask;
        if (sl_u <= sh_u) begin
            n_item.span[0] = '{en: !viol && (l_cut <= r_cut), lo: l_cut, hi: r_cut};
            n_item.span[1] = '{en: 1'b0, lo: l_cut, hi: i_u_high};
        end else begin
            // The signed range wraps through the sign boundary: two spans.
            n_item.span[0] = '{en: !viol && (i_u_low <= r_cut), lo: i_u_low, hi: r_cut};
            n_item.span[1] = '{en: !viol && (l_cut <= i_u_high), lo: l_cut, hi: i_u_high};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/adic_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adic_queue
// Short item queue between the front and the back part.
// ----------------------------------------------------------------------------
module adic_queue
    import adic_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);

    t_item [QUEUE_DEPTH-1:0] r_mem;
    logic [QPTR_W-1:0]       r_wptr;
    logic [QPTR_W-1:0]       r_rptr;
    logic [QCNT_W-1:0]       r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/adic_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adic_back
// Pipeline that cuts spans into pieces, derives the 32-bit intervals, runs
// the next-member step on every interval and merges the answers.
// ----------------------------------------------------------------------------
module adic_back
    import adic_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_valid,
    input  wire t_item i_item,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output logic       o_nonempty,
    output logic       o_bounds_violation
);

    logic adv;

    // Stage 1: pieces.
    logic                     r_s1_vld;
    t_range [NUM_PIECES-1:0]  r_s1_piece;
    t_range [NUM_PIECES-1:0]  n_s1_piece;
    t_item                    r_s1_item;
    // Stage 2: intervals.
    logic                     r_s2_vld;
    t_range [NUM_IVALS-1:0]   r_s2_ival;
    t_range [NUM_IVALS-1:0]   n_s2_ival;
    logic                     r_s2_viol;
    logic                     r_s2_norm;
    logic [WORD_W-1:0]        r_s2_v;
    logic [WORD_W-1:0]        r_s2_m;
    // Stage 3: first half of the step.
    logic                     r_s3_vld;
    t_stepa [NUM_IVALS-1:0]   r_s3_step;
    t_stepa [NUM_IVALS-1:0]   n_s3_step;
    logic                     r_s3_viol;
    logic                     r_s3_norm;
    logic [WORD_W-1:0]        r_s3_v;
    logic [WORD_W-1:0]        r_s3_m;
    // Stage 4: next member found.
    logic                     r_s4_vld;
    t_stepb [NUM_IVALS-1:0]   r_s4_step;
    t_stepb [NUM_IVALS-1:0]   n_s4_step;
    logic                     r_s4_viol;
    logic                     r_s4_norm;
    // Output register.
    logic                     r_out_valid;
    logic                     r_nonempty;
    logic                     r_viol;
    logic                     n_nonempty;

    assign adv                = !r_out_valid || i_out_ready;
    assign o_pop              = adv && i_q_valid;
    assign o_out_valid        = r_out_valid;
    assign o_nonempty         = r_nonempty;
    assign o_bounds_violation = r_viol;

    always_comb begin
        logic [HALF_W-1:0] xh;
        logic [HALF_W-1:0] yh;
        logic              same;
        logic [HALF_W-1:0] xh_inc;
        logic [HALF_W-1:0] yh_dec;
        t_range            sp;
        for (int s = 0; s < NUM_SPANS; s++) begin
            sp     = i_item.span[s];
            xh     = sp.lo[WORD_W-1:HALF_W];
            yh     = sp.hi[WORD_W-1:HALF_W];
            same   = (xh == yh);
            xh_inc = xh + 1'b1;
            yh_dec = yh - 1'b1;
            n_s1_piece[s*PIECES_PER_SPAN] =
                '{en: sp.en, lo: sp.lo, hi: same ? sp.hi : {xh, HALF_ONES}};
            n_s1_piece[s*PIECES_PER_SPAN+1] =
                '{en: sp.en && !same && (xh_inc <= yh_dec),
                  lo: {xh_inc, HALF_ZERO}, hi: {yh_dec, HALF_ONES}};
            n_s1_piece[s*PIECES_PER_SPAN+2] =
                '{en: sp.en && !same, lo: {yh, HALF_ZERO}, hi: sp.hi};
        end
    end

    always_comb begin
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] a2;
        logic [WORD_W-1:0] b2;
        t_range            p;
        for (int i = 0; i < NUM_PIECES; i++) begin
            p  = r_s1_piece[i];
            a  = fn_max(p.lo & LOW_HALF, WORD_W'(r_s1_item.wl));
            b  = fn_min(p.hi & LOW_HALF, WORD_W'(r_s1_item.wh));
            a2 = fn_max(a, WORD_W'(r_s1_item.wsl));
            b2 = fn_min(b, WORD_W'(r_s1_item.wsh));
            n_s2_ival[i*IVALS_PER_PIECE+IVAL_WIDE] = p;
            n_s2_ival[i*IVALS_PER_PIECE+IVAL_LOW]  = '{en: p.en && (a <= b), lo: a, hi: b};
            if (r_s1_item.norm) begin
                n_s2_ival[i*IVALS_PER_PIECE+IVAL_LOW_A] =
                    '{en: p.en && (a2 <= b2), lo: a2, hi: b2};
            end else begin
                n_s2_ival[i*IVALS_PER_PIECE+IVAL_LOW_A] =
                    '{en: p.en && (a <= b2), lo: a, hi: b2};
            end
            n_s2_ival[i*IVALS_PER_PIECE+IVAL_LOW_B] = '{en: p.en && (a2 <= b), lo: a2, hi: b};
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_IVALS; k++) begin
            if ((k % IVALS_PER_PIECE) == IVAL_WIDE) begin
                n_s3_step[k] = fn_step_a(r_s2_ival[k], r_s2_v, r_s2_m);
                n_s4_step[k] = fn_step_b(r_s3_step[k], r_s3_v, r_s3_m);
            end else begin
                n_s3_step[k] = fn_step_a(r_s2_ival[k], r_s2_v & LOW_HALF, r_s2_m & LOW_HALF);
                n_s4_step[k] = fn_step_b(r_s3_step[k], r_s3_v & LOW_HALF, r_s3_m & LOW_HALF);
            end
        end
    end

    always_comb begin
        logic [NUM_IVALS-1:0] hit;
        logic                 piece_hit;
        for (int k = 0; k < NUM_IVALS; k++) begin
            hit[k] = r_s4_step[k].en && (r_s4_step[k].nxt <= r_s4_step[k].hi);
        end
        n_nonempty = 1'b0;
        for (int i = 0; i < NUM_PIECES; i++) begin
            piece_hit = hit[i*IVALS_PER_PIECE+IVAL_WIDE] && hit[i*IVALS_PER_PIECE+IVAL_LOW] &&
                        (r_s4_norm ? hit[i*IVALS_PER_PIECE+IVAL_LOW_A]
                                   : (hit[i*IVALS_PER_PIECE+IVAL_LOW_A] ||
                                      hit[i*IVALS_PER_PIECE+IVAL_LOW_B]));
            n_nonempty = n_nonempty || piece_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_s4_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_vld    <= i_q_valid;
            r_s2_vld    <= r_s1_vld;
            r_s3_vld    <= r_s2_vld;
            r_s4_vld    <= r_s3_vld;
            r_out_valid <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_piece <= n_s1_piece;
            r_s1_item  <= i_item;
            r_s2_ival  <= n_s2_ival;
            r_s2_viol  <= r_s1_item.viol;
            r_s2_norm  <= r_s1_item.norm;
            r_s2_v     <= r_s1_item.v;
            r_s2_m     <= r_s1_item.m;
            r_s3_step  <= n_s3_step;
            r_s3_viol  <= r_s2_viol;
            r_s3_norm  <= r_s2_norm;
            r_s3_v     <= r_s2_v;
            r_s3_m     <= r_s2_m;
            r_s4_step  <= n_s4_step;
            r_s4_viol  <= r_s3_viol;
            r_s4_norm  <= r_s3_norm;
            r_nonempty <= n_nonempty;
            r_viol     <= r_s4_viol;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/abstract_domain_intersection_check.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// abstract_domain_intersection_check
// Reports whether one concrete 64-bit value fits all five register
// abstractions of an item, and flags inverted ranges.
// ----------------------------------------------------------------------------
// Usage: an item carries the unsigned and signed 64-bit ranges, the unsigned
// and signed ranges of the low 32 bits and a tristate number. It is taken
// when i_in_valid and o_in_ready are high at a rising edge. One result item
// (o_nonempty, o_bounds_violation) comes back per input item, in order, and
// is taken when o_out_valid and i_out_ready are both high.
// An accepted item passes the front register, a queue entry and the four
// back pipeline stages before the output register loads. Throughput is one
// item per cycle while the receiver does not stall; the back pipeline's step
// units are replicated for all twenty-four intervals, so nothing is shared.
// When the receiver stalls, the back pipeline holds as a whole while the
// two-entry queue and the front register keep accepting, so o_in_ready falls
// once the front register and both queue entries are occupied, after at most
// three more items have been taken.
// A synchronous active-low reset empties the queue and all pipeline stages;
// no result is pending afterwards.
// ----------------------------------------------------------------------------
module abstract_domain_intersection_check
    import adic_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [WORD_W-1:0]        i_u_low,
    input  wire logic [WORD_W-1:0]        i_u_high,
    input  wire logic signed [WORD_W-1:0] i_s_low,
    input  wire logic signed [WORD_W-1:0] i_s_high,
    input  wire logic [HALF_W-1:0]        i_w_low,
    input  wire logic [HALF_W-1:0]        i_w_high,
    input  wire logic signed [HALF_W-1:0] i_ws_low,
    input  wire logic signed [HALF_W-1:0] i_ws_high,
    input  wire logic [WORD_W-1:0]        i_known_bits,
    input  wire logic [WORD_W-1:0]        i_unknown_mask,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic                          o_nonempty,
    output logic                          o_bounds_violation
);

    // Front to queue.
    logic  push;
    logic  q_full;
    t_item front_item;
    // Queue to back.
    logic  pop;
    logic  q_valid;
    t_item q_item;

    adic_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_u_low        (i_u_low),
        .i_u_high       (i_u_high),
        .i_s_low        (i_s_low),
        .i_s_high       (i_s_high),
        .i_w_low        (i_w_low),
        .i_w_high       (i_w_high),
        .i_ws_low       (i_ws_low),
        .i_ws_high      (i_ws_high),
        .i_known_bits   (i_known_bits),
        .i_unknown_mask (i_unknown_mask),
        .o_push         (push),
        .i_q_full       (q_full),
        .o_item         (front_item)
    );

    adic_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    adic_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_item             (q_item),
        .o_pop              (pop),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_nonempty         (o_nonempty),
        .o_bounds_violation (o_bounds_violation)
    );

endmodule
`default_nettype wire

// ----- hdl/adic_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adic_port_checks
// Port-level checks of the intersection check block.
// ----------------------------------------------------------------------------
module adic_port_checks (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire logic o_nonempty,
    input wire logic o_bounds_violation
);

    // An inverted range never comes with an intersection.
    a_viol_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bounds_violation |-> !o_nonempty)
        else $error("bounds violation reported together with an intersection");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_nonempty) && $stable(o_bounds_violation))
        else $error("stalled result changed");

endmodule

bind abstract_domain_intersection_check adic_port_checks u_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_nonempty         (o_nonempty),
    .o_bounds_violation (o_bounds_violation)
);
`default_nettype wire

// ----- tb/sv/adic_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adic_checker
// Watches both channels of the intersection check, predicts each result
// item from the accepted input item and compares them in order.
// ----------------------------------------------------------------------------
module adic_checker
    import adic_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic                     i_in_ready,
    input  wire logic [WORD_W-1:0]        i_u_low,
    input  wire logic [WORD_W-1:0]        i_u_high,
    input  wire logic signed [WORD_W-1:0] i_s_low,
    input  wire logic signed [WORD_W-1:0] i_s_high,
    input  wire logic [HALF_W-1:0]        i_w_low,
    input  wire logic [HALF_W-1:0]        i_w_high,
    input  wire logic signed [HALF_W-1:0] i_ws_low,
    input  wire logic signed [HALF_W-1:0] i_ws_high,
    input  wire logic [WORD_W-1:0]        i_known_bits,
    input  wire logic [WORD_W-1:0]        i_unknown_mask,
    input  wire logic                     i_out_valid,
    input  wire logic                     i_out_ready,
    input  wire logic                     i_nonempty,
    input  wire logic                     i_bounds_violation,
    output int                            o_errors,
    output int                            o_pending
);

    typedef struct packed {
        logic hit;
        logic viol;
    } t_verdict;

    t_verdict verdict_q[$];

    localparam logic [63:0] LOW32 = 64'h0000_0000_FFFF_FFFF;

    // Smallest tristate member at or above z; ok is cleared when none exists.
    function automatic logic [63:0] next_member(input logic [63:0] v, input logic [63:0] m,
                                                input logic [63:0] z, output logic ok);
        logic [63:0] diff, hb, above, cand, j;
        ok = 1'b1;
        if ((z & ~m) == v) return z;
        diff = (z ^ v) & ~m;
        hb = 64'h8000_0000_0000_0000;
        while ((diff & hb) == 0) hb = hb >> 1;
        above = ~((hb << 1) - 64'd1);
        if ((v & hb) != 0) return (z & m & above) | v;
        cand = ~z & m & above;
        if (cand == 0) begin
            ok = 1'b0;
            return z;
        end
        j = cand & (64'd0 - cand);
        return (z & m & ~((j << 1) - 64'd1)) | j | v;
    endfunction

    function automatic logic hits(input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [63:0] v, input logic [63:0] m);
        logic ok;
        logic [63:0] nx;
        if (v > hi || (v | m) < lo) return 1'b0;
        nx = next_member(v, m, lo, ok);
        return ok && nx <= hi;
    endfunction

    function automatic logic [63:0] umax(input logic [63:0] a, input logic [63:0] b);
        return a > b ? a : b;
    endfunction

    function automatic logic [63:0] umin(input logic [63:0] a, input logic [63:0] b);
        return a < b ? a : b;
    endfunction

    // Per-item domain, captured when the item is accepted.
    logic [63:0] d_wl, d_wh, d_wsl, d_wsh, d_v, d_m;

    function automatic logic low_fits(input logic [63:0] l, input logic [63:0] r);
        logic [63:0] v32, m32, a, b, a2, b2;
        v32 = d_v & LOW32;
        m32 = d_m & LOW32;
        a = umax(l, d_wl);
        b = umin(r, d_wh);
        if (a > b || !hits(a, b, v32, m32)) return 1'b0;
        if (d_wsl <= d_wsh) begin
            a2 = umax(a, d_wsl);
            b2 = umin(b, d_wsh);
            return a2 <= b2 && hits(a2, b2, v32, m32);
        end
        b2 = umin(b, d_wsh);
        if (a <= b2 && hits(a, b2, v32, m32)) return 1'b1;
        a2 = umax(a, d_wsl);
        return a2 <= b && hits(a2, b, v32, m32);
    endfunction

    function automatic logic piece_fits(input logic [63:0] lo, input logic [63:0] hi);
        if (!hits(lo, hi, d_v, d_m)) return 1'b0;
        return low_fits(lo & LOW32, hi & LOW32);
    endfunction

    // A span is cut where the upper 32-bit half changes.
    function automatic logic span_fits(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] xh, yh;
        xh = x >> 32;
        yh = y >> 32;
        if (xh == yh) return piece_fits(x, y);
        if (piece_fits(x, (xh << 32) | LOW32)) return 1'b1;
        if (xh + 1 <= yh - 1 && piece_fits((xh + 1) << 32, (yh << 32) - 1)) return 1'b1;
        return piece_fits(yh << 32, y);
    endfunction

    function automatic t_verdict predict_verdict();
        t_verdict    res;
        logic [63:0] ul, uh, sl, sh, l, r;
        ul = i_u_low;
        uh = i_u_high;
        sl = i_s_low;
        sh = i_s_high;
        res.hit = 1'b0;
        res.viol = ul > uh || $signed(sl) > $signed(sh) || i_w_low > i_w_high
                   || i_ws_low > i_ws_high;
        if (!res.viol) begin
            if (sl <= sh) begin
                l = umax(ul, sl);
                r = umin(uh, sh);
                res.hit = l <= r && span_fits(l, r);
            end else begin
                // The signed range wraps through the sign boundary.
                r = umin(uh, sh);
                res.hit = ul <= r && span_fits(ul, r);
                if (!res.hit) begin
                    l = umax(ul, sl);
                    res.hit = l <= uh && span_fits(l, uh);
                end
            end
        end
        return res;
    endfunction

    t_verdict got, want;

    initial o_errors = 0;
    assign o_pending = verdict_q.size();

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                d_wl  = {32'd0, i_w_low};
                d_wh  = {32'd0, i_w_high};
                d_wsl = {32'd0, i_ws_low};
                d_wsh = {32'd0, i_ws_high};
                d_m   = i_unknown_mask;
                d_v   = i_known_bits & ~i_unknown_mask;
                verdict_q.push_back(predict_verdict());
            end
            if (i_out_valid && i_out_ready) begin
                got.hit  = i_nonempty;
                got.viol = i_bounds_violation;
                if (verdict_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("%0t: result item with nothing expected", $realtime);
                end else begin
                    want = verdict_q.pop_front();
                    if (got !== want) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("%0t: nonempty exp %b got %b, violation exp %b got %b",
                                     $realtime, want.hit, got.hit, want.viol, got.viol);
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/tb_abstract_domain_intersection_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_abstract_domain_intersection_check
// Drives directed and random register abstractions into the block with
// random gaps and stalls, and leaves prediction to the checker module.
// ----------------------------------------------------------------------------
module tb_abstract_domain_intersection_check;
    import adic_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [WORD_W-1:0]        i_u_low = '0;
    logic [WORD_W-1:0]        i_u_high = '0;
    logic signed [WORD_W-1:0] i_s_low = '0;
    logic signed [WORD_W-1:0] i_s_high = '0;
    logic [HALF_W-1:0]        i_w_low = '0;
    logic [HALF_W-1:0]        i_w_high = '0;
    logic signed [HALF_W-1:0] i_ws_low = '0;
    logic signed [HALF_W-1:0] i_ws_high = '0;
    logic [WORD_W-1:0]        i_known_bits = '0;
    logic [WORD_W-1:0]        i_unknown_mask = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic                     o_nonempty;
    logic                     o_bounds_violation;
    int                       errors;
    int                       pending;

    // Set while the sender is finished, or while the long receiver hold-off runs.
    logic                     sender_done = 1'b0;
    logic                     hold_off = 1'b0;
    // Set by the sender when the stall phase begins.
    logic                     want_hold = 1'b0;

    always #4 i_clk = ~i_clk;

    abstract_domain_intersection_check uut (.*);

    adic_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready),
        .i_u_low, .i_u_high, .i_s_low, .i_s_high, .i_w_low, .i_w_high,
        .i_ws_low, .i_ws_high, .i_known_bits, .i_unknown_mask,
        .i_out_valid(o_out_valid), .i_out_ready, .i_nonempty(o_nonempty),
        .i_bounds_violation(o_bounds_violation),
        .o_errors(errors), .o_pending(pending)
    );

    // Random 64-bit value biased toward the interesting boundaries: zero,
    // all ones, the sign bit and the 32-bit half boundaries.
    function automatic logic [63:0] rnd64();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000 ^ 64'($urandom_range(0, 3));
            3: return {$urandom(), 32'd0} - 64'($urandom_range(0, 2));
            4: return {32'($urandom_range(0, 3)), $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Puts one item on the input channel and waits for it to be taken. Valid
    // stays high afterwards; the caller drops it before any idle cycle.
    task automatic send_item(input logic [63:0] ul, uh, sl, sh,
                             input logic [31:0] wl, wh, wsl, wsh,
                             input logic [63:0] kb, um);
        i_u_low <= ul;  i_u_high <= uh;  i_s_low <= sl;  i_s_high <= sh;
        i_w_low <= wl;  i_w_high <= wh;  i_ws_low <= wsl;  i_ws_high <= wsh;
        i_known_bits <= kb;  i_unknown_mask <= um;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Well-formed item: ordered ranges around a value drawn from the tristate
    // number, so that most items get far into the piece and member search.
    task automatic send_random(input logic quiet);
        logic [63:0] kb, um, x, ul, uh, sl, sh;
        logic [31:0] wl, wh, wsl, wsh;
        int          gap;
        kb = rnd64();
        um = rnd64() & (($urandom_range(0, 1) != 0) ? {$urandom(), $urandom()} : '1);
        x  = (kb & ~um) | ({$urandom(), $urandom()} & um);
        if ($urandom_range(0, 9) == 0) begin
            // Noise: fully random and often inverted ranges.
            ul = rnd64(); uh = rnd64(); sl = rnd64(); sh = rnd64();
            wl = $urandom(); wh = $urandom(); wsl = $urandom(); wsh = $urandom();
        end else begin
            ul = ($urandom_range(0, 3) == 0) ? 64'd0 : x - 64'($urandom_range(0, 1 << 20));
            uh = ($urandom_range(0, 3) == 0) ? '1 : x + 64'($urandom_range(0, 1 << 20));
            if (ul > x) ul = 64'd0;
            if (uh < x) uh = '1;
            sl = ($urandom_range(0, 2) == 0) ? 64'h8000_0000_0000_0000 : x - rnd64() % 64'd9000;
            sh = ($urandom_range(0, 2) == 0) ? 64'h7FFF_FFFF_FFFF_FFFF : x + rnd64() % 64'd9000;
            if ($signed(sl) > $signed(sh)) begin
                sl = 64'h8000_0000_0000_0000;
                sh = 64'h7FFF_FFFF_FFFF_FFFF;
            end
            wl = $urandom_range(0, 1) ? 32'd0 : x[31:0] - $urandom_range(0, 1 << 12);
            wh = $urandom_range(0, 1) ? '1 : x[31:0] + $urandom_range(0, 1 << 12);
            if (wl > wh) begin wl = 32'd0; wh = '1; end
            wsl = $urandom_range(0, 1) ? 32'h8000_0000 : x[31:0] - $urandom_range(0, 1 << 12);
            wsh = $urandom_range(0, 1) ? 32'h7FFF_FFFF : x[31:0] + $urandom_range(0, 1 << 12);
            if ($signed(wsl) > $signed(wsh)) begin wsl = 32'h8000_0000; wsh = 32'h7FFF_FFFF; end
            // Occasionally nudge the unsigned lower bound just above the drawn value.
            if ($urandom_range(0, 4) == 0) ul = x + 1;
        end
        gap = quiet ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        send_item(ul, uh, sl, sh, wl, wh, wsl, wsh, kb, um);
    endtask

    // Receiver: a random stall before each result item, or the long hold-off.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (want_hold) begin
                hold_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (60) @(negedge i_clk);
                hold_off = 1'b0;
                want_hold = 1'b0;
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
            if (stall == 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Stimulus.
    initial begin
        logic [63:0] all1;
        all1 = '1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items: every range inverted on its own, full ranges with
        // full and empty tristates, the sign wrap, a known bit that is also
        // unknown, and a bound above which the tristate has no member.
        send_item(64'd5, 64'd4, 64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF,
                  32'd0, '1, 32'h8000_0000, 32'h7FFF_FFFF, 64'd0, all1);
        send_item(64'd0, all1, 64'sd1, -64'sd1, 32'd0, '1, 32'h8000_0000, 32'h7FFF_FFFF,
                  64'd0, all1);
        send_item(64'd0, all1, 64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF,
                  32'd9, 32'd8, 32'h8000_0000, 32'h7FFF_FFFF, 64'd0, all1);
        send_item(64'd0, all1, 64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF,
                  32'd0, '1, 32'd1, 32'hFFFF_FFFF, 64'd0, all1);
        send_item(64'd0, all1, 64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF,
                  32'd0, '1, 32'h8000_0000, 32'h7FFF_FFFF, 64'd0, all1);
        send_item(64'd0, all1, 64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF,
                  32'd0, '1, 32'h8000_0000, 32'h7FFF_FFFF, all1, 64'd0);
        send_item(64'd0, 64'd0, 64'sd0, 64'sd0, 32'd0, 32'd0, 32'd0, 32'd0, 64'd0, 64'd0);
        send_item(all1, all1, -64'sd1, -64'sd1, '1, '1, '1, '1, all1, 64'd0);
        // Wrapping signed range: values near zero and near the top.
        send_item(64'd0, all1, -64'sd3, 64'sd2, 32'd0, '1, 32'h8000_0000, 32'h7FFF_FFFF,
                  64'd0, 64'h3);
        send_item(64'd4, 64'hFFFF_FFFF_FFFF_FFF0, -64'sd3, 64'sd2, 32'd0, '1,
                  32'h8000_0000, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0, 64'hF);
        // Known bit also unknown.
        send_item(64'd0, 64'd3, 64'sd0, 64'sd3, 32'd0, '1, 32'd0, 32'd3, 64'h4, 64'h5);
        // No member at or above the lower bound.
        send_item(64'd9, all1, 64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF,
                  32'd0, '1, 32'h8000_0000, 32'h7FFF_FFFF, 64'd0, 64'h7);
        // Range across a 32-bit half boundary, middle pieces included.
        send_item(64'h0000_0001_FFFF_FFF0, 64'h0000_0005_0000_0010,
                  64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF,
                  32'h20, 32'h30, 32'h8000_0000, 32'h7FFF_FFFF, 64'h0, 64'hF_FFFF_FF3F);
        // Low half must satisfy a wrapping signed 32-bit range.
        send_item(64'd0, all1, 64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF,
                  32'd0, '1, 32'hFFFF_FFF0, 32'h10, 64'h0000_0000_8000_0000, 64'h0);
        send_item(64'd0, all1, 64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF,
                  32'd0, '1, 32'hFFFF_FFF0, 32'h10, 64'h0000_0000_FFFF_FFF8, 64'h3);

        // Sender pause until every expected result has come.
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        for (int n = 0; n < 500; n++) begin
            if (n == 150) begin
                // Long receiver hold-off while items keep coming back to back.
                i_in_valid <= 1'b0;
                want_hold = 1'b1;
                while (!hold_off) @(negedge i_clk);
            end
            send_random(hold_off || (n >= 300 && n < 340));
            if (n == 400) begin
                i_in_valid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
        sender_done = 1'b1;
    end

    // Verdict.
    initial begin
        int guard;
        guard = 0;
        wait (sender_done);
        while (pending != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- abstract_domain_intersection_check.f -----
hdl/adic_pkg.sv
hdl/adic_front.sv
hdl/adic_queue.sv
hdl/adic_back.sv
hdl/abstract_domain_intersection_check.sv
hdl/adic_checker.sv
tb/sv/adic_checker.sv
tb/sv/tb_abstract_domain_intersection_check.sv
